>>> hdl/mwov_pkg.sv
// Shared types, codes and constants of the mecanum odometry velocity block.
package mwov_pkg;

  // pi * 1.28e8, rounded; folds 2*pi and the Q16.16 and Q8.8 scalings together.
  localparam logic [31:0] PI_SCALED = 32'd402123860;
  // Extra 2^16 on the yaw numerator, so the yaw quotient lands in Q16.16.
  localparam logic [31:0] YAW_SCALE = 32'h0001_0000;
  localparam logic [31:0] UNIT_GAIN = 32'd1;

  localparam int LIMB_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 5;
  localparam int IN_DATA_W = 160;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [23:0] RST_WHEEL_RADIUS   = 24'd3277;
  localparam logic [23:0] RST_HALF_LENGTH    = 24'd13107;
  localparam logic [23:0] RST_HALF_WIDTH     = 24'd11076;
  localparam logic [15:0] RST_COUNTS_PER_REV = 16'd42;
  localparam logic [15:0] RST_GEAR_RATIO     = 16'd1280;

  typedef struct packed {
    logic [23:0] wheel_radius;
    logic [23:0] half_length;
    logic [23:0] half_width;
    logic [15:0] counts_per_rev;
    logic [15:0] gear_ratio;
  } cfg_t;

  // Multiply passes over the limb lanes.
  typedef enum logic [1:0] {
    PASS_GAIN = 2'd0,
    PASS_PI   = 2'd1,
    PASS_TAIL = 2'd2
  } pass_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  take_first;
    logic  take;
    logic  sum;
    logic  load;
    logic  mul;
    logic  mul_first;
    pass_t pass;
    logic  div_load;
    logic  div_step;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
  } dp_stat_t;

endpackage

>>> hdl/mecanum_wheel_odometry_velocity.sv
// Top level of the mecanum wheel odometry velocity block: config registers and wiring.
//
//  Channel  Direction  Payload
//  in_      slave      tdata: count_front_left, count_front_right, count_rear_left,
//                      count_rear_right, stamp_us (32 bits each, lowest first)
//  out_     master     tdata: speed_x, speed_y, yaw_rate (Q16.16); tuser: status
//  cfg_     write      cfg_index selects the register, cfg_wdata carries the value
//
// A full sample goes through three limb-serial multiply passes and 32 divider steps before
// the output register write; input is ready again in the cycle after it. The first sample
// after reset only records counts and stamp; a zero-interval one skips multiply and divide.
// Reset is synchronous and active low; it restores the register defaults and the
// first-sample flag, with no clearing pass. A stalled output holds its item while the
// next sample is accepted and worked on; only the final write into it waits.
module mecanum_wheel_odometry_velocity
  import mwov_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int STAMP_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // count_front_left, count_front_right, count_rear_left, count_rear_right, stamp_us
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result items.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // speed_x, speed_y, yaw_rate
  output logic [95:0]           out_tdata,
  // status
  output logic                  out_tuser,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The widest intermediate decides the limb count: the yaw numerator carries
  // the count sum (COUNT_WIDTH + 2 bits), radius, pi constant and 2^16; the yaw
  // divisor carries the interval, counts per revolution, gear ratio and the
  // half wheelbase plus half track.
  localparam int NUM_BITS = COUNT_WIDTH + 71;
  localparam int DEN_BITS = STAMP_WIDTH + 57;
  localparam int MAX_BITS = (NUM_BITS > DEN_BITS) ? NUM_BITS : DEN_BITS;
  localparam int LIMBS    = (MAX_BITS + LIMB_W - 1) / LIMB_W;

  cfg_t        cfg_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] speed_x, speed_y, yaw_rate;
  logic        status;

  // The user must issue register writes only while the block is idle; the block itself
  // does not enforce it. Indexes past the last register are dropped; excess high bits ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_radius   <= RST_WHEEL_RADIUS;
      cfg_r.half_length    <= RST_HALF_LENGTH;
      cfg_r.half_width     <= RST_HALF_WIDTH;
      cfg_r.counts_per_rev <= RST_COUNTS_PER_REV;
      cfg_r.gear_ratio     <= RST_GEAR_RATIO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WHEEL_RADIUS:   cfg_r.wheel_radius   <= cfg_wdata;
        REG_HALF_LENGTH:    cfg_r.half_length    <= cfg_wdata;
        REG_HALF_WIDTH:     cfg_r.half_width     <= cfg_wdata;
        REG_COUNTS_PER_REV: cfg_r.counts_per_rev <= cfg_wdata[15:0];
        REG_GEAR_RATIO:     cfg_r.gear_ratio     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // The controller steps each sample through delta capture, summing, the
  // multiply passes and the division, and it owns the output valid flag.
  mwov_ctrl #(.LIMBS(LIMBS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath keeps the previous counts and stamp, builds the wheel sums,
  // scales numerators and divisors limb by limb and saturates the quotients.
  mwov_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH),
    .LIMBS       (LIMBS)
  ) u_datapath (
    .clk      (clk),
    .cfg      (cfg_r),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .speed_x  (speed_x),
    .speed_y  (speed_y),
    .yaw_rate (yaw_rate),
    .status   (status)
  );

  assign out_tdata = {yaw_rate, speed_y, speed_x};
  assign out_tuser = status;

endmodule

>>> hdl/mwov_divider.sv
// Restoring divider lane: 32 quotient bits, one per cycle while step is high, with overflow flag.
module mwov_divider
  import mwov_pkg::*;
#(
  parameter int NB = 128
) (
  input  logic          clk,
  input  logic          load,
  input  logic          step,
  input  logic [NB-1:0] num,
  input  logic [NB-1:0] den,
  output logic [31:0]   quot,
  output logic          big
);

  logic [NB-1:0] rem_r;
  logic [31:0]   q_r;
  logic          big_r;
  logic [NB:0]   shifted;
  logic [NB:0]   den_ext;
  logic          ge;

  assign den_ext = {1'b0, den};
  assign shifted = {rem_r, q_r[31]};
  assign ge      = (shifted >= den_ext);

  always_ff @(posedge clk) begin
    if (load) begin
      // A quotient of 2^32 or more shows up as the high part not below the divisor.
      rem_r <= NB'(num[NB-1:LIMB_W]);
      q_r   <= num[LIMB_W-1:0];
      big_r <= (NB'(num[NB-1:LIMB_W]) >= den);
    end else if (step) begin
      rem_r <= ge ? NB'(shifted - den_ext) : NB'(shifted);
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign quot = q_r;
  assign big  = big_r;

endmodule

>>> hdl/mwov_datapath.sv
// Datapath: count deltas, limb-serial multiply lanes, divider lanes, result register.
module mwov_datapath
  import mwov_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int STAMP_WIDTH = 32,
  parameter int LIMBS       = 4
) (
  input  logic                 clk,
  input  cfg_t                 cfg,
  input  logic [IN_DATA_W-1:0] in_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [31:0]          speed_x,
  output logic [31:0]          speed_y,
  output logic [31:0]          yaw_rate,
  output logic                 status
);

  localparam int NB    = LIMBS * LIMB_W;
  localparam int SUM_W = COUNT_WIDTH + 2;
  localparam int LANES = 5;

  logic [COUNT_WIDTH-1:0] cur [4];
  logic [STAMP_WIDTH-1:0] stamp;
  logic [COUNT_WIDTH-1:0] last_cnt_r [4];
  logic [STAMP_WIDTH-1:0] last_stamp_r;
  logic [COUNT_WIDTH-1:0] delta_r [4];
  logic [STAMP_WIDTH-1:0] dt_r;
  logic signed [SUM_W-1:0] dx [4];
  logic signed [SUM_W-1:0] sum_r [3];
  logic [SUM_W-1:0] mag [3];
  logic             neg_r [3];
  logic [NB-1:0]    acc_r [LANES];
  logic [31:0]      carry_r [LANES];
  logic [31:0]      fac [LANES];
  logic [63:0]      prod [LANES];
  logic [31:0]      quot [3];
  logic             big [3];
  logic [24:0]      half_sum;
  logic             err;
  logic             yzero;
  logic [31:0]      speed_x_r, speed_y_r, yaw_rate_r;
  logic             status_r;

  function automatic logic [31:0] sat_q(input logic [31:0] q, input logic ovf,
                                        input logic neg);
    logic [31:0] lim;
    logic [31:0] qs;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    qs  = (ovf || (q > lim)) ? lim : q;
    return neg ? (32'd0 - qs) : qs;
  endfunction

  for (genvar i = 0; i < 4; i++) begin : g_cur
    assign cur[i] = COUNT_WIDTH'(in_data[i*32 +: 32]);
    assign dx[i]  = SUM_W'(signed'(delta_r[i]));
  end
  assign stamp = STAMP_WIDTH'(in_data[159:128]);

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign mag[i] = sum_r[i][SUM_W-1] ? unsigned'(-sum_r[i]) : unsigned'(sum_r[i]);
  end

  assign half_sum = 25'(cfg.half_length) + 25'(cfg.half_width);
  assign err   = (dt_r == '0) || (cfg.counts_per_rev == '0) || (cfg.gear_ratio == '0);
  assign yzero = (half_sum == '0);
  assign stat.err = err;

  // Factor of each lane in each pass. Lanes 0..2 are the x, y and yaw numerators,
  // lane 3 the common divisor and lane 4 the yaw divisor.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      fac[j] = UNIT_GAIN;
    end
    case (cmd.pass)
      PASS_GAIN: begin
        for (int j = 0; j < 3; j++) fac[j] = 32'(cfg.wheel_radius);
        fac[3] = 32'(cfg.counts_per_rev);
        fac[4] = 32'(cfg.counts_per_rev);
      end
      PASS_PI: begin
        for (int j = 0; j < 3; j++) fac[j] = PI_SCALED;
        fac[3] = 32'(cfg.gear_ratio);
        fac[4] = 32'(cfg.gear_ratio);
      end
      PASS_TAIL: begin
        fac[2] = YAW_SCALE;
        fac[4] = 32'(half_sum);
      end
      default: ;
    endcase
  end

  for (genvar j = 0; j < LANES; j++) begin : g_prod
    assign prod[j] = 64'(acc_r[j][LIMB_W-1:0]) * 64'(fac[j])
                   + 64'(cmd.mul_first ? 32'd0 : carry_r[j]);
  end

  always_ff @(posedge clk) begin
    if (cmd.take_first) begin
      for (int i = 0; i < 4; i++) last_cnt_r[i] <= cur[i];
      last_stamp_r <= stamp;
    end
    if (cmd.take) begin
      for (int i = 0; i < 4; i++) begin
        delta_r[i]    <= cur[i] - last_cnt_r[i];
        last_cnt_r[i] <= cur[i];
      end
      dt_r         <= stamp - last_stamp_r;
      last_stamp_r <= stamp;
    end
    if (cmd.sum) begin
      sum_r[0] <=  dx[0] + dx[1] + dx[2] + dx[3];
      sum_r[1] <= -dx[0] + dx[1] + dx[2] - dx[3];
      sum_r[2] <= -dx[0] + dx[1] - dx[2] + dx[3];
    end
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= sum_r[i][SUM_W-1];
        acc_r[i] <= NB'(mag[i]);
      end
      acc_r[3] <= NB'(dt_r);
      acc_r[4] <= NB'(dt_r);
    end else if (cmd.mul) begin
      // Low limb is multiplied, the product limb rotates in at the top.
      for (int j = 0; j < LANES; j++) begin
        acc_r[j]   <= {prod[j][31:0], acc_r[j][NB-1:LIMB_W]};
        carry_r[j] <= prod[j][63:32];
      end
    end
    if (cmd.out_load) begin
      speed_x_r  <= err ? 32'd0 : sat_q(quot[0], big[0], neg_r[0]);
      speed_y_r  <= err ? 32'd0 : sat_q(quot[1], big[1], neg_r[1]);
      yaw_rate_r <= (err || yzero) ? 32'd0 : sat_q(quot[2], big[2], neg_r[2]);
      status_r   <= err;
    end
  end

  mwov_divider #(.NB(NB)) u_div_x (
    .clk (clk), .load (cmd.div_load), .step (cmd.div_step),
    .num (acc_r[0]), .den (acc_r[3]), .quot (quot[0]), .big (big[0])
  );

  mwov_divider #(.NB(NB)) u_div_y (
    .clk (clk), .load (cmd.div_load), .step (cmd.div_step),
    .num (acc_r[1]), .den (acc_r[3]), .quot (quot[1]), .big (big[1])
  );

  mwov_divider #(.NB(NB)) u_div_w (
    .clk (clk), .load (cmd.div_load), .step (cmd.div_step),
    .num (acc_r[2]), .den (acc_r[4]), .quot (quot[2]), .big (big[2])
  );

  assign speed_x  = speed_x_r;
  assign speed_y  = speed_y_r;
  assign yaw_rate = yaw_rate_r;
  assign status   = status_r;

endmodule

>>> hdl/mwov_ctrl.sv
// Controller: sequences one sample through the datapath and owns both handshakes.
module mwov_ctrl
  import mwov_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  pass_t            pass_r, pass_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= PASS_GAIN;
      cnt_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.pass      = pass_r;
    in_tready     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (first_r) begin
            cmd.take_first = 1'b1;
            first_nxt      = 1'b0;
          end else begin
            cmd.take  = 1'b1;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        cnt_nxt  = '0;
        pass_nxt = PASS_GAIN;
        state_nxt = stat.err ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul       = 1'b1;
        cmd.mul_first = (cnt_r == '0);
        if (cnt_r == CNT_W'(LIMBS - 1)) begin
          cnt_nxt = '0;
          case (pass_r)
            PASS_GAIN: pass_nxt = PASS_PI;
            PASS_PI:   pass_nxt = PASS_TAIL;
            default:   state_nxt = ST_DIV_LOAD;
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
